### design/pic_pkg.sv
// pic_pkg: shared constants, payload structs, opcodes and state encoding
// for the platform interrupt controller; no dependencies
package pic_pkg;

    localparam int SRC_COUNT    = 64;
    localparam int NUM_CONTEXTS = 4;

    localparam int ADDR_W    = 26;
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 2;
    localparam int SID_W     = 6;
    localparam int PRIO_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_CFG   = 4;

    localparam int SRC_W     = $clog2(SRC_COUNT);
    localparam int CTX_W     = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int SRC_WORDS = SRC_COUNT / 32;
    localparam int WSEL_W    = (SRC_WORDS > 1) ? $clog2(SRC_WORDS) : 1;

    localparam int PRIO_LEN  = SRC_COUNT * 4;
    localparam int PEND_LEN  = SRC_COUNT / 8;
    localparam int EN_STRIDE = 'h80;
    localparam int EN_LEN    = NUM_CONTEXTS * EN_STRIDE;
    localparam int CL_STRIDE = 'h1000;
    localparam int CL_LEN    = NUM_CONTEXTS * CL_STRIDE;
    localparam int EN_SHIFT  = $clog2(EN_STRIDE);
    localparam int CL_SHIFT  = $clog2(CL_STRIDE);
    localparam int EN_USED   = SRC_COUNT / 8;

    localparam logic [CL_SHIFT-1:0] THR_OFS   = CL_SHIFT'('h0);
    localparam logic [CL_SHIFT-1:0] CLAIM_OFS = CL_SHIFT'('h4);

    localparam logic [ADDR_W-1:0] PRIO_BASE_RST  = ADDR_W'('h0);
    localparam logic [ADDR_W-1:0] PEND_BASE_RST  = ADDR_W'('h1000);
    localparam logic [ADDR_W-1:0] EN_BASE_RST    = ADDR_W'('h2000);
    localparam logic [ADDR_W-1:0] CLAIM_BASE_RST = ADDR_W'('h200000);

    typedef enum logic [MODE_W-1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_RAISE = 2'd2,
        MODE_LOWER = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRIO_BASE  = 2'd0,
        CFG_PEND_BASE  = 2'd1,
        CFG_EN_BASE    = 2'd2,
        CFG_CLAIM_BASE = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ERR,
        OP_PRIO_RD,
        OP_PRIO_WR,
        OP_PEND_RD,
        OP_EN_RD,
        OP_EN_WR,
        OP_THR_RD,
        OP_THR_WR,
        OP_CLAIM,
        OP_RAISE,
        OP_LOWER
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_FINISH,
        ST_SCAN_FIND,
        ST_CLAIM,
        ST_SCAN_LOWER,
        ST_DROP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic [SID_W-1:0]  source_id;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0]       read_data;
        logic                    access_error;
        logic [NUM_CONTEXTS-1:0] irq_lines;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic decode;
        logic exec;
        logic finish;
        logic scan_start;
        logic claim_take;
        logic lines_drop;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic scan_done;
        logic first_found;
    } t_dp_status;

endpackage

### design/platform_interrupt_controller.sv
// platform_interrupt_controller: top level joining sequencer and datapath
// request flow: load, decode and execute, then a finish step for priority read and
// raise, a source scan for lower and claim (a claim that finds a source scans a
// second time to drop lines), then the result is loaded; scans read one source a cycle
// a new request is taken only when idle, after the last result was loaded, longer while a result waits
// reset: synchronous, clears all state at once, no clearing pass
module platform_interrupt_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  pic_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output pic_pkg::t_out_item            o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pic_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pic_pkg::ADDR_W-1:0]    i_cfg_data
);
    import pic_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    pic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pic_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

### design/pic_ctrl.sv
// pic_ctrl: sequencer for request decode, execute, source scans and
// result hand-off; depends on pic_pkg
module pic_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  pic_pkg::t_dp_status i_status,
    output pic_pkg::t_dp_cmd    o_cmd
);
    import pic_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                case (i_status.op) inside
                    OP_PRIO_RD, OP_RAISE: n_state = ST_FINISH;
                    OP_LOWER: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN_LOWER;
                    end
                    OP_CLAIM: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN_FIND;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_DONE;
            end
            ST_SCAN_FIND: begin
                if (i_status.scan_done) begin
                    n_state = ST_CLAIM;
                end
            end
            ST_CLAIM: begin
                o_cmd.claim_take = 1'b1;
                if (i_status.first_found) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN_LOWER;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN_LOWER: begin
                if (i_status.scan_done) begin
                    n_state = ST_DROP;
                end
            end
            ST_DROP: begin
                o_cmd.lines_drop = 1'b1;
                n_state          = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### design/pic_datapath.sv
// pic_datapath: region bases, address decode, priority memory, pending,
// enable and threshold state, source scan and result registers; uses pic_pkg
module pic_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pic_pkg::t_dp_cmd              i_cmd,
    output pic_pkg::t_dp_status           o_status,
    input  pic_pkg::t_in_item             i_in,
    output pic_pkg::t_out_item            o_out,
    input  logic                          i_cfg_we,
    input  logic [pic_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pic_pkg::ADDR_W-1:0]    i_cfg_data
);
    import pic_pkg::*;

    // configuration
    logic [NUM_CFG-1:0][ADDR_W-1:0] r_base;

    // architectural state
    logic [PRIO_W-1:0]                         r_prio_mem [SRC_COUNT];
    logic [SRC_COUNT-1:0]                      r_prio_vld;
    logic [SRC_COUNT-1:0]                      r_pend;
    logic [NUM_CONTEXTS-1:0][SRC_COUNT-1:0]    r_en;
    logic [NUM_CONTEXTS-1:0][PRIO_W-1:0]       r_thr;
    logic [NUM_CONTEXTS-1:0]                   r_lines;

    // request and decode
    t_in_item          r_req;
    t_op               r_op;
    t_op               n_op;
    logic [SRC_W-1:0]  r_src;
    logic [SRC_W-1:0]  n_src;
    logic [CTX_W-1:0]  r_ctx;
    logic [CTX_W-1:0]  n_ctx;
    logic [WSEL_W-1:0] r_wsel;
    logic [WSEL_W-1:0] n_wsel;

    // result
    logic [DATA_W-1:0] r_rdata;
    logic              r_err;
    t_out_item         r_out;

    // priority read port
    logic [SRC_W-1:0]  rd_addr;
    logic [PRIO_W-1:0] r_mem_q;
    logic              r_vld_q;
    logic [PRIO_W-1:0] prio_q;
    logic              prio_we;

    // scan
    logic                    r_scan_run;
    logic [SRC_W-1:0]        r_scan_idx;
    logic                    r_chk;
    logic                    r_chk_last;
    logic [SRC_W-1:0]        r_chk_idx;
    logic [NUM_CONTEXTS-1:0] r_found;
    logic [SRC_W-1:0]        r_first;
    logic                    r_first_found;
    logic [NUM_CONTEXTS-1:0] elig;

    // decode terms
    logic [ADDR_W:0]   d_prio;
    logic [ADDR_W:0]   d_pend;
    logic [ADDR_W:0]   d_en;
    logic [ADDR_W:0]   d_cl;
    logic              hit_prio;
    logic              hit_pend;
    logic              hit_en;
    logic              hit_cl;
    logic              is_wr;
    logic              ev_ok;
    logic [ADDR_W-1:0] a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base[CFG_PRIO_BASE]  <= PRIO_BASE_RST;
            r_base[CFG_PEND_BASE]  <= PEND_BASE_RST;
            r_base[CFG_EN_BASE]    <= EN_BASE_RST;
            r_base[CFG_CLAIM_BASE] <= CLAIM_BASE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PRIO_BASE:  r_base[CFG_PRIO_BASE]  <= i_cfg_data;
                CFG_PEND_BASE:  r_base[CFG_PEND_BASE]  <= i_cfg_data;
                CFG_EN_BASE:    r_base[CFG_EN_BASE]    <= i_cfg_data;
                CFG_CLAIM_BASE: r_base[CFG_CLAIM_BASE] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // address decode
    assign a     = r_req.address;
    assign is_wr = (r_req.mode == MODE_WRITE);
    assign ev_ok = (r_req.source_id != '0) && (32'(r_req.source_id) < SRC_COUNT);

    assign d_prio = {1'b0, a} - {1'b0, r_base[CFG_PRIO_BASE]};
    assign d_pend = {1'b0, a} - {1'b0, r_base[CFG_PEND_BASE]};
    assign d_en   = {1'b0, a} - {1'b0, r_base[CFG_EN_BASE]};
    assign d_cl   = {1'b0, a} - {1'b0, r_base[CFG_CLAIM_BASE]};

    assign hit_prio = !d_prio[ADDR_W] && (d_prio[ADDR_W-1:0] < ADDR_W'(PRIO_LEN));
    assign hit_pend = !d_pend[ADDR_W] && (d_pend[ADDR_W-1:0] < ADDR_W'(PEND_LEN));
    assign hit_en   = !d_en[ADDR_W]   && (d_en[ADDR_W-1:0]   < ADDR_W'(EN_LEN));
    assign hit_cl   = !d_cl[ADDR_W]   && (d_cl[ADDR_W-1:0]   < ADDR_W'(CL_LEN));

    always_comb begin
        n_op   = OP_ERR;
        n_src  = SRC_W'(d_prio[ADDR_W-1:2]);
        n_ctx  = CTX_W'(d_en[ADDR_W-1:EN_SHIFT]);
        n_wsel = WSEL_W'(a[EN_SHIFT-1:2]);
        case (r_req.mode) inside
            MODE_RAISE, MODE_LOWER: begin
                n_src = SRC_W'(r_req.source_id);
                if (!ev_ok) begin
                    n_op = OP_NOP;
                end else if (r_req.mode == MODE_RAISE) begin
                    n_op = OP_RAISE;
                end else begin
                    n_op = OP_LOWER;
                end
            end
            default: begin
                if (a[1:0] != 2'b00) begin
                    n_op = OP_ERR;
                end else if (hit_prio) begin
                    n_op = is_wr ? OP_PRIO_WR : OP_PRIO_RD;
                end else if (hit_pend) begin
                    n_wsel = WSEL_W'(d_pend[ADDR_W-1:2]);
                    n_op   = is_wr ? OP_ERR : OP_PEND_RD;
                end else if (hit_en) begin
                    if (32'(a[EN_SHIFT-1:0]) >= EN_USED) begin
                        n_op = OP_ERR;
                    end else begin
                        n_op = is_wr ? OP_EN_WR : OP_EN_RD;
                    end
                end else if (hit_cl) begin
                    n_ctx = CTX_W'(d_cl[ADDR_W-1:CL_SHIFT]);
                    if (a[CL_SHIFT-1:0] == THR_OFS) begin
                        n_op = is_wr ? OP_THR_WR : OP_THR_RD;
                    end else if (a[CL_SHIFT-1:0] == CLAIM_OFS) begin
                        n_op = is_wr ? OP_ERR : OP_CLAIM;
                    end else begin
                        n_op = OP_ERR;
                    end
                end else begin
                    n_op = OP_ERR;
                end
            end
        endcase
    end

    // priority memory, one read port shared by requests and scans
    assign rd_addr = r_scan_run ? r_scan_idx : r_src;
    assign prio_we = i_cmd.exec && (r_op == OP_PRIO_WR);
    assign prio_q  = r_vld_q ? r_mem_q : '0;

    always_ff @(posedge i_clk) begin
        if (prio_we) begin
            r_prio_mem[r_src] <= r_req.write_data[PRIO_W-1:0];
        end
        r_mem_q <= r_prio_mem[rd_addr];
        r_vld_q <= r_prio_vld[rd_addr];
    end

    // eligibility of the source under check
    always_comb begin
        for (int c = 0; c < NUM_CONTEXTS; c++) begin
            elig[c] = r_pend[r_chk_idx] && r_en[c][r_chk_idx] && (prio_q >= r_thr[c]);
        end
    end

    // scan sequencing and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio_vld <= '0;
            r_pend     <= '0;
            r_en       <= '0;
            r_thr      <= '0;
            r_lines    <= '0;
            r_scan_run <= 1'b0;
            r_chk      <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_scan_run <= 1'b1;
                r_chk      <= 1'b0;
            end else if (r_scan_run) begin
                r_chk <= 1'b1;
                if (r_scan_idx == SRC_W'(SRC_COUNT - 1)) begin
                    r_scan_run <= 1'b0;
                end
            end else begin
                r_chk <= 1'b0;
            end

            if (prio_we) begin
                r_prio_vld[r_src] <= 1'b1;
            end
            if (i_cmd.exec) begin
                case (r_op)
                    OP_EN_WR:  r_en[r_ctx][r_wsel*32 +: 32] <= r_req.write_data;
                    OP_THR_WR: r_thr[r_ctx] <= r_req.write_data[PRIO_W-1:0];
                    OP_LOWER:  r_pend[r_src] <= 1'b0;
                    default: ;
                endcase
            end
            if (i_cmd.finish && (r_op == OP_RAISE)) begin
                r_pend[r_src] <= 1'b1;
                for (int c = 0; c < NUM_CONTEXTS; c++) begin
                    if (r_en[c][r_src] && (prio_q >= r_thr[c])) begin
                        r_lines[c] <= 1'b1;
                    end
                end
            end
            if (i_cmd.claim_take && r_first_found) begin
                r_pend[r_first] <= 1'b0;
            end
            if (i_cmd.lines_drop) begin
                r_lines <= r_lines & r_found;
            end
        end
    end

    // request, decode, scan results and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_in;
            r_rdata <= '0;
            r_err   <= 1'b0;
        end
        if (i_cmd.decode) begin
            r_op   <= n_op;
            r_src  <= n_src;
            r_ctx  <= n_ctx;
            r_wsel <= n_wsel;
        end
        if (i_cmd.exec) begin
            case (r_op)
                OP_ERR:     r_err   <= 1'b1;
                OP_PEND_RD: r_rdata <= r_pend[r_wsel*32 +: 32];
                OP_EN_RD:   r_rdata <= r_en[r_ctx][r_wsel*32 +: 32];
                OP_THR_RD:  r_rdata <= DATA_W'(r_thr[r_ctx]);
                default: ;
            endcase
        end
        if (i_cmd.finish && (r_op == OP_PRIO_RD)) begin
            r_rdata <= DATA_W'(prio_q);
        end
        if (i_cmd.claim_take) begin
            r_rdata <= r_first_found ? DATA_W'(r_first) : '0;
        end

        if (i_cmd.scan_start) begin
            r_scan_idx    <= '0;
            r_found       <= '0;
            r_first_found <= 1'b0;
        end else begin
            if (r_scan_run) begin
                r_scan_idx <= r_scan_idx + 1'b1;
                r_chk_idx  <= r_scan_idx;
                r_chk_last <= (r_scan_idx == SRC_W'(SRC_COUNT - 1));
            end
            if (r_chk) begin
                r_found <= r_found | elig;
                if (elig[r_ctx] && !r_first_found) begin
                    r_first       <= r_chk_idx;
                    r_first_found <= 1'b1;
                end
            end
        end

        if (i_cmd.out_load) begin
            r_out.read_data    <= r_rdata;
            r_out.access_error <= r_err;
            r_out.irq_lines    <= r_lines;
        end
    end

    assign o_status.op          = r_op;
    assign o_status.scan_done   = r_chk && r_chk_last;
    assign o_status.first_found = r_first_found;
    assign o_out                = r_out;

endmodule

### tb/tb_platform_interrupt_controller.sv
// tb_platform_interrupt_controller: self-checking bench for the interrupt controller;
// predicts each response from its own copy of the register state and compares in order
// depends on pic_pkg and platform_interrupt_controller
module tb_platform_interrupt_controller;
    import pic_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_in_item in_req;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out_item out_rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0] cfg_data;

    logic [PRIO_W-1:0] model_prio [SRC_COUNT];
    logic [PRIO_W-1:0] model_thresh [NUM_CONTEXTS];
    logic [31:0] model_pending [SRC_WORDS];
    logic [31:0] model_enable [NUM_CONTEXTS*SRC_WORDS];
    logic [NUM_CONTEXTS-1:0] model_lines;
    logic [ADDR_W-1:0] base_prio, base_pend, base_en, base_claim;

    t_out_item due_responses [$];
    int error_count = 0;
    int burst_left = 0;
    logic sender_gaps_on = 1'b1;
    int ready_mode = 0;
    int ready_left = 0;
    int stall_left = 0;

    platform_interrupt_controller dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #12_000_000;
        $display("tb_platform_interrupt_controller: done, errors");
        $finish;
    end

    function automatic void reset_model();
        for (int s = 0; s < SRC_COUNT; s++) model_prio[s] = '0;
        for (int c = 0; c < NUM_CONTEXTS; c++) model_thresh[c] = '0;
        for (int w = 0; w < SRC_WORDS; w++) model_pending[w] = '0;
        for (int w = 0; w < NUM_CONTEXTS*SRC_WORDS; w++) model_enable[w] = '0;
        model_lines = '0;
        base_prio  = PRIO_BASE_RST;
        base_pend  = PEND_BASE_RST;
        base_en    = EN_BASE_RST;
        base_claim = CLAIM_BASE_RST;
    endfunction

    function automatic logic eligible(int ctx, int s);
        return model_pending[s / 32][s % 32] && model_enable[ctx*SRC_WORDS + s / 32][s % 32]
            && model_prio[s] >= model_thresh[ctx];
    endfunction

    function automatic int first_eligible(int ctx);
        for (int s = 0; s < SRC_COUNT; s++) begin
            if (eligible(ctx, s)) return s;
        end
        return 0;
    endfunction

    function automatic void raise_source(int s);
        if (s == 0 || s >= SRC_COUNT) return;
        model_pending[s / 32][s % 32] = 1'b1;
        for (int c = 0; c < NUM_CONTEXTS; c++) begin
            if (model_enable[c*SRC_WORDS + s / 32][s % 32] && model_prio[s] >= model_thresh[c])
                model_lines[c] = 1'b1;
        end
    endfunction

    // source 0 is never pending, so a zero scan means nothing eligible
    function automatic void drop_source(int s);
        if (s == 0 || s >= SRC_COUNT) return;
        model_pending[s / 32][s % 32] = 1'b0;
        for (int c = 0; c < NUM_CONTEXTS; c++) begin
            if (first_eligible(c) == 0) model_lines[c] = 1'b0;
        end
    endfunction

    function automatic logic in_span(logic [31:0] a, logic [31:0] base, int len);
        return a >= base && a < base + 32'(len);
    endfunction

    function automatic t_out_item register_access(logic wr, logic [31:0] a, logic [31:0] wd);
        t_out_item r;
        int idx;
        int ctx;
        int s;
        r = '0;
        r.access_error = 1'b1;
        if (a[1:0] != 2'b00) return r;
        if (in_span(a, 32'(base_prio), PRIO_LEN)) begin
            idx = int'((a - base_prio) >> 2);
            if (wr) model_prio[idx] = wd[PRIO_W-1:0];
            else r.read_data = 32'(model_prio[idx]);
            r.access_error = 1'b0;
            return r;
        end
        if (in_span(a, 32'(base_pend), PEND_LEN)) begin
            if (!wr) begin
                r.read_data = model_pending[int'((a - base_pend) >> 2)];
                r.access_error = 1'b0;
            end
            return r;
        end
        if (in_span(a, 32'(base_en), EN_LEN)) begin
            ctx = int'((a - base_en) >> EN_SHIFT);
            if (a[EN_SHIFT-1:0] >= EN_USED) return r;
            idx = ctx*SRC_WORDS + int'(a[EN_SHIFT-1:0] >> 2);
            if (wr) model_enable[idx] = wd;
            else r.read_data = model_enable[idx];
            r.access_error = 1'b0;
            return r;
        end
        if (in_span(a, 32'(base_claim), CL_LEN)) begin
            ctx = int'((a - base_claim) >> CL_SHIFT);
            if (a[CL_SHIFT-1:0] == THR_OFS) begin
                if (wr) model_thresh[ctx] = wd[PRIO_W-1:0];
                else r.read_data = 32'(model_thresh[ctx]);
                r.access_error = 1'b0;
            end else if (a[CL_SHIFT-1:0] == CLAIM_OFS && !wr) begin
                s = first_eligible(ctx);
                drop_source(s);
                r.read_data = 32'(s);
                r.access_error = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic t_out_item compute_response(t_in_item it);
        t_out_item r;
        r = '0;
        case (it.mode)
            MODE_READ: r = register_access(1'b0, 32'(it.address), it.write_data);
            MODE_WRITE: begin
                r = register_access(1'b1, 32'(it.address), it.write_data);
                r.read_data = '0;
            end
            MODE_RAISE: raise_source(int'(it.source_id));
            default: drop_source(int'(it.source_id));
        endcase
        r.irq_lines = model_lines;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] prio_addr(int s);
        return ADDR_W'(32'(base_prio) + 32'(4*s));
    endfunction

    function automatic logic [ADDR_W-1:0] pend_addr(int w);
        return ADDR_W'(32'(base_pend) + 32'(4*w));
    endfunction

    function automatic logic [ADDR_W-1:0] en_addr(int c, int w);
        return ADDR_W'(32'(base_en) + 32'(c*EN_STRIDE + 4*w));
    endfunction

    function automatic logic [ADDR_W-1:0] thr_addr(int c);
        return ADDR_W'(32'(base_claim) + 32'(c*CL_STRIDE) + 32'(THR_OFS));
    endfunction

    function automatic logic [ADDR_W-1:0] claim_addr(int c);
        return ADDR_W'(32'(base_claim) + 32'(c*CL_STRIDE) + 32'(CLAIM_OFS));
    endfunction

    function automatic logic [ADDR_W-1:0] edge_address();
        logic [31:0] base;
        int len;
        case ($urandom_range(0, 3))
            0: begin base = 32'(base_prio); len = PRIO_LEN; end
            1: begin base = 32'(base_pend); len = PEND_LEN; end
            2: begin base = 32'(base_en); len = EN_LEN; end
            default: begin base = 32'(base_claim); len = CL_LEN; end
        endcase
        case ($urandom_range(0, 4))
            0: return ADDR_W'(base - 4);
            1: return ADDR_W'(base);
            2: return ADDR_W'(base + 32'(len) - 4);
            3: return ADDR_W'(base + 32'(len));
            default: return ADDR_W'(base + $urandom_range(0, len - 1));
        endcase
    endfunction

    function automatic t_in_item request(t_mode m, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d,
                                         logic [SID_W-1:0] s);
        t_in_item it;
        it.mode = m;
        it.address = a;
        it.write_data = d;
        it.source_id = s;
        return it;
    endfunction

    function automatic t_in_item random_request();
        t_in_item it;
        int pick;
        int ctx;
        int src;
        pick = $urandom_range(0, 99);
        ctx = $urandom_range(0, NUM_CONTEXTS - 1);
        src = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, SRC_COUNT - 1);
        it = request(MODE_READ, ADDR_W'($urandom), $urandom, SID_W'($urandom));
        if (pick < 22) begin
            it.mode = MODE_RAISE;
            it.source_id = SID_W'(src);
        end else if (pick < 32) begin
            it.mode = MODE_LOWER;
            it.source_id = SID_W'(src);
        end else if (pick < 52) begin
            it.address = claim_addr(ctx);
        end else if (pick < 62) begin
            it.mode = MODE_WRITE;
            it.address = prio_addr(src);
        end else if (pick < 68) begin
            it.mode = MODE_WRITE;
            it.address = thr_addr(ctx);
        end else if (pick < 76) begin
            it.mode = MODE_WRITE;
            it.address = en_addr(ctx, $urandom_range(0, SRC_WORDS - 1));
        end else if (pick < 88) begin
            case ($urandom_range(0, 3))
                0: it.address = prio_addr(src);
                1: it.address = pend_addr($urandom_range(0, SRC_WORDS - 1));
                2: it.address = en_addr(ctx, $urandom_range(0, SRC_WORDS - 1));
                default: it.address = thr_addr(ctx);
            endcase
        end else begin
            it.mode = t_mode'($urandom_range(0, 1));
            if ($urandom_range(0, 1)) it.address = edge_address();
        end
        return it;
    endfunction

    function automatic void note_mismatch(string what, t_out_item want, t_out_item got);
        error_count++;
        if (error_count <= 10)
            $display("%s: expected rd=%h err=%b irq=%b, got rd=%h err=%b irq=%b", what,
                     want.read_data, want.access_error, want.irq_lines,
                     got.read_data, got.access_error, got.irq_lines);
    endfunction

    always @(posedge clk) begin : check_responses
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (due_responses.size() == 0) begin
                note_mismatch("response with no request", '0, out_rsp);
            end else begin
                want = due_responses.pop_front();
                if (out_rsp.read_data !== want.read_data
                    || out_rsp.access_error !== want.access_error
                    || out_rsp.irq_lines !== want.irq_lines)
                    note_mismatch("response mismatch", want, out_rsp);
            end
        end
    end

    always @(negedge clk) begin
        if (ready_left == 0) begin
            ready_left = $urandom_range(50, 400);
            ready_mode = $urandom_range(0, 3);
        end
        ready_left--;
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: begin
                if (stall_left > 0) begin
                    stall_left--;
                    out_ready <= 1'b0;
                end else begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 24);
                end
            end
            default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send_request(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (!sender_gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_req <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        due_responses.push_back(compute_response(it));
    endtask

    task automatic write_base(input t_cfg_idx idx, input logic [ADDR_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_PRIO_BASE: base_prio = value;
            CFG_PEND_BASE: base_pend = value;
            CFG_EN_BASE:   base_en = value;
            default:       base_claim = value;
        endcase
    endtask

    task automatic apply_bases(input logic [ADDR_W-1:0] b_prio, input logic [ADDR_W-1:0] b_pend,
                               input logic [ADDR_W-1:0] b_en, input logic [ADDR_W-1:0] b_claim);
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_responses.size() != 0) @(posedge clk);
        write_base(CFG_PRIO_BASE, b_prio);
        write_base(CFG_PEND_BASE, b_pend);
        write_base(CFG_EN_BASE, b_en);
        write_base(CFG_CLAIM_BASE, b_claim);
        @(negedge clk);
        cfg_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic probe_regions();
        repeat (12)
            send_request(request(t_mode'($urandom_range(0, 1)), edge_address(), $urandom,
                                 SID_W'($urandom)));
        repeat (8) send_request(random_request());
    endtask

    task automatic test_register_map();
        send_request(request(MODE_WRITE, prio_addr(5), 32'hffff_fffd, '0));
        send_request(request(MODE_READ, prio_addr(5), '0, '0));
        send_request(request(MODE_WRITE, prio_addr(6), 32'h2, '1));
        send_request(request(MODE_WRITE, en_addr(0, 0), 32'h60, '0));
        send_request(request(MODE_WRITE, thr_addr(0), 32'hffff_fff3, '0));
        // priority below threshold, no line
        send_request(request(MODE_RAISE, '0, '0, 6'd6));
        send_request(request(MODE_RAISE, '0, '0, 6'd5));
        // register writes leave the lines alone
        send_request(request(MODE_WRITE, thr_addr(0), 32'h7, '0));
        send_request(request(MODE_READ, pend_addr(0), '0, '0));
        send_request(request(MODE_WRITE, pend_addr(0), '1, '0));
        send_request(request(MODE_READ, '1, '1, '0));
        send_request(request(MODE_READ, 26'h3ff_fffc, '0, '0));
        send_request(request(MODE_READ, en_addr(0, 2), '0, '0));
        send_request(request(MODE_READ, ADDR_W'(claim_addr(0) + 4), '0, '0));
        send_request(request(MODE_WRITE, claim_addr(0), '1, '0));
        send_request(request(MODE_READ, claim_addr(0), '0, '0));
        send_request(request(MODE_WRITE, thr_addr(0), '0, '0));
        // claim with another source still eligible keeps the line
        send_request(request(MODE_READ, claim_addr(0), '0, '0));
        send_request(request(MODE_LOWER, '0, '0, 6'd6));
        send_request(request(MODE_RAISE, '0, '0, '0));
        send_request(request(MODE_WRITE, en_addr(3, 1), 32'h8000_0000, '0));
        send_request(request(MODE_RAISE, '0, '0, '1));
        send_request(request(MODE_READ, en_addr(3, 1), '0, '0));
        send_request(request(MODE_READ, pend_addr(1), '0, '0));
        send_request(request(MODE_LOWER, '0, '0, '1));
    endtask

    task automatic test_region_relocation();
        apply_bases('0, '0, '0, '0);
        probe_regions();
        apply_bases('1, '1, '1, '1);
        probe_regions();
        apply_bases(26'h3ff_ff00, '0, 26'h104_4, 26'h3ff_c000);
        probe_regions();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 3)
                0: apply_bases(PRIO_BASE_RST, PEND_BASE_RST, EN_BASE_RST, CLAIM_BASE_RST);
                1: apply_bases({14'($urandom_range(0, 'h3ffb)), 12'h0},
                               {14'($urandom_range(0, 'h3ffb)), 12'h0},
                               {14'($urandom_range(0, 'h3ffb)), 12'h0},
                               {14'($urandom_range(0, 'h3ffb)), 12'h0});
                default: apply_bases(ADDR_W'($urandom), ADDR_W'($urandom),
                                     ADDR_W'($urandom), ADDR_W'($urandom));
            endcase
            sender_gaps_on = (phase % 4 != 2);
            repeat (240) send_request(random_request());
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_req = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PRIO_BASE;
        cfg_data = '0;
        reset_model();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_map();
        test_region_relocation();
        test_random_traffic();

        @(negedge clk);
        in_valid <= 1'b0;
        while (due_responses.size() != 0) @(posedge clk);
        repeat (2*SRC_COUNT + 20) @(posedge clk);
        if (error_count == 0) begin
            $display("tb_platform_interrupt_controller: done, clean");
        end else begin
            $display("tb_platform_interrupt_controller: done, errors");
        end
        $finish;
    end

endmodule

### files.f
design/pic_pkg.sv
design/pic_ctrl.sv
design/pic_datapath.sv
design/platform_interrupt_controller.sv
tb/tb_platform_interrupt_controller.sv
